/* src/swrl_pkg.sv */
// ----------------------------------------------------------------------------
// swrl_pkg
// Shared types and constants for the sliding window rate limiter.
// ----------------------------------------------------------------------------
`default_nettype none

package swrl_pkg;

    localparam int RING_DEPTH = 256;
    localparam int TIME_WIDTH = 32;

    localparam int IDX_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int CNT_W = $clog2(RING_DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;

    localparam int NOW_W = 32;
    localparam int WIN_W = 32;
    localparam int MAX_W = 9;
    localparam int OCC_W = 9;
    localparam int CMP_W = (CNT_W > MAX_W) ? CNT_W : MAX_W;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_MS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_REQUESTS = 2'd1;

    localparam logic [WIN_W-1:0] WINDOW_RESET = 32'd1000;
    localparam logic [MAX_W-1:0] MAX_RESET    = 9'd100;

    typedef logic [TIME_WIDTH-1:0] t_stamp;
    typedef logic [IDX_W-1:0]      t_idx;
    typedef logic [CNT_W-1:0]      t_cnt;

    // result of the shared subtractor
    typedef struct packed {
        t_stamp diff;
        logic   borrow;
    } t_sub_res;

    typedef enum logic [1:0] {
        S_IDLE  = 2'b01,
        S_CHECK = 2'b10
    } t_state;

endpackage

`default_nettype wire

/* src/sliding_window_rate_limiter.sv */
// ----------------------------------------------------------------------------
// sliding_window_rate_limiter
// Sliding window log rate limiter over a ring of granted request timestamps.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                  payload
//  in        input      i_in_valid / o_in_stall    i_action, i_now_ms
//  out       output     o_out_valid / i_out_stall  o_allowed, o_occupancy
//  cfg       input      i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
//  an item pops one expired timestamp per cycle in the compare state, then
//  takes its result; the single subtractor and the ring's one read port set this pace.
//  reset clears the state, head, count, output valid and config registers; ring
//  contents and the data registers stay undefined, no clearing pass is run.
//  a stalled result is held in the output register; the next item can be
//  taken meanwhile and waits in the compare state until the register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module sliding_window_rate_limiter
    import swrl_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,

    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire logic                 i_action,
    input  wire logic [NOW_W-1:0]     i_now_ms,

    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output logic                      o_allowed,
    output logic      [OCC_W-1:0]     o_occupancy,

    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [WIN_W-1:0]     i_cfg_data
);

    t_state           r_state, n_state;
    t_idx             r_head, n_head;
    t_cnt             r_count, n_count;
    logic             r_clear;
    t_stamp           r_now;
    t_stamp           r_start;
    logic [WIN_W-1:0] r_window_ms;
    logic [MAX_W-1:0] r_max_requests;
    logic             r_out_valid, n_out_valid;
    logic             r_allowed, n_allowed;
    logic [OCC_W-1:0] r_occ, n_occ;

    logic             w_in_xfer;
    logic             w_out_free;
    logic             w_pop;
    logic             w_grant;
    logic             w_we;
    t_idx             w_tail;
    t_idx             w_head_inc;
    logic [SUM_W-1:0] w_sum;
    logic [CMP_W-1:0] w_limit;
    logic [CMP_W-1:0] w_max_ext;
    t_stamp           w_rdata;
    t_stamp           w_op_a, w_op_b;
    t_sub_res         w_sub;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_allowed   = r_allowed;
    assign o_occupancy = r_occ;

    assign w_in_xfer  = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;

    // shared subtractor: window start on accept, expiry compare afterwards
    always_comb begin
        if (r_state == S_IDLE) begin
            w_op_a = TIME_WIDTH'(i_now_ms);
            w_op_b = TIME_WIDTH'(r_window_ms);
        end else begin
            w_op_a = w_rdata;
            w_op_b = r_start;
        end
    end

    swrl_sub u_sub (
        .i_a   (w_op_a),
        .i_b   (w_op_b),
        .o_res (w_sub)
    );

    // effective limit never exceeds the ring depth
    assign w_max_ext = CMP_W'(r_max_requests);
    assign w_limit   = (w_max_ext > CMP_W'(RING_DEPTH)) ? CMP_W'(RING_DEPTH) : w_max_ext;

    assign w_sum  = SUM_W'(r_head) + SUM_W'(r_count);
    assign w_tail = (w_sum >= SUM_W'(RING_DEPTH)) ? IDX_W'(w_sum - SUM_W'(RING_DEPTH))
                                                   : IDX_W'(w_sum);
    assign w_head_inc = (r_head == IDX_W'(RING_DEPTH - 1)) ? '0 : r_head + 1'b1;

    assign w_pop   = (r_state == S_CHECK) && !r_clear && (r_count != '0) && w_sub.borrow;
    assign w_grant = (CMP_W'(r_count) < w_limit);
    assign w_we    = (r_state == S_CHECK) && !r_clear && !w_pop && w_out_free && w_grant;

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_count     = r_count;
        n_out_valid = r_out_valid && i_out_stall;
        n_allowed   = r_allowed;
        n_occ       = r_occ;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_xfer) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (r_clear) begin
                    if (w_out_free) begin
                        n_head      = '0;
                        n_count     = '0;
                        n_out_valid = 1'b1;
                        n_allowed   = 1'b0;
                        n_occ       = '0;
                        n_state     = S_IDLE;
                    end
                end else if (w_pop) begin
                    n_head  = w_head_inc;
                    n_count = r_count - 1'b1;
                end else if (w_out_free) begin
                    if (w_grant) begin
                        n_count = r_count + 1'b1;
                    end
                    n_out_valid = 1'b1;
                    n_allowed   = w_grant;
                    n_occ       = OCC_W'(n_count);
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // read address follows the next head so the registered read data matches the head in the next cycle
    swrl_ram #(
        .WIDTH (TIME_WIDTH),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_tail),
        .i_wdata (r_now),
        .i_raddr (n_head),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_head         <= '0;
            r_count        <= '0;
            r_out_valid    <= 1'b0;
            r_window_ms    <= WINDOW_RESET;
            r_max_requests <= MAX_RESET;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_WINDOW_MS:    r_window_ms    <= i_cfg_data;
                    CFG_MAX_REQUESTS: r_max_requests <= i_cfg_data[MAX_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_allowed <= n_allowed;
        r_occ     <= n_occ;
        if (w_in_xfer) begin
            r_clear <= i_action;
            r_now   <= TIME_WIDTH'(i_now_ms);
            r_start <= w_sub.diff;
        end
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(RING_DEPTH))
        else $error("ring count above depth");

    a_accept_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer |=> (r_state == S_CHECK))
        else $error("accepted item did not enter the compare state");

    a_grant_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_allowed) |-> (o_occupancy != '0))
        else $error("granted result with empty log");

    a_write_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> (CMP_W'(r_count) < w_limit) && !w_pop)
        else $error("log write beyond limit or during pop");
`endif

endmodule

`default_nettype wire

/* src/swrl_ram.sv */
// ----------------------------------------------------------------------------
// swrl_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module swrl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

/* src/swrl_sub.sv */
// ----------------------------------------------------------------------------
// swrl_sub
// Shared subtractor: forms the window start and does the expiry compare.
// ----------------------------------------------------------------------------
`default_nettype none

module swrl_sub
    import swrl_pkg::*;
(
    input  wire t_stamp   i_a,
    input  wire t_stamp   i_b,
    output t_sub_res      o_res
);

    logic [TIME_WIDTH:0] w_full;

    // borrow out means a < b, unsigned
    assign w_full       = {1'b0, i_a} - {1'b0, i_b};
    assign o_res.diff   = w_full[TIME_WIDTH-1:0];
    assign o_res.borrow = w_full[TIME_WIDTH];

endmodule

`default_nettype wire
